>>> rtl/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
// No dependencies.
package ffba_pkg;

  localparam int DEF_MAX_BLOCKS = 64;
  localparam int DEF_ADDR_BITS  = 32;

  localparam logic [31:0] HEAP_BASE_RST   = 32'h1000_0000;
  localparam logic [31:0] HEAP_LIMIT_RST  = 32'hFFFF_FFFF;
  localparam logic [26:0] MAX_REQUEST_RST = 27'd100_000_000;
  localparam logic [7:0]  HEADER_RST      = 8'd40;

  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_ZALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE   = 2'd2;
  localparam logic [1:0] REQ_RESIZE = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE  = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [1:0] CFG_HEAP_BASE  = 2'd0;
  localparam logic [1:0] CFG_HEAP_LIMIT = 2'd1;
  localparam logic [1:0] CFG_MAX_REQ    = 2'd2;
  localparam logic [1:0] CFG_HEADER     = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] request_size;
    logic [15:0] element_count;
    logic [31:0] block_address;
  } req_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [1:0]  status;
    logic [26:0] copy_bytes;
    logic [6:0]  free_block_count;
    logic [31:0] free_byte_count;
    logic [6:0]  allocated_block_count;
    logic [31:0] allocated_byte_count;
    logic [13:0] header_byte_count;
  } rsp_t;

endpackage

>>> rtl/first_fit_block_allocator.sv
// First-fit heap block allocator over a block table held in one memory.
// A scan reads one table entry per cycle (memory read port), and a resize
// may scan twice (address, then first fit).
// Throughput: one transaction at a time; the next is taken once the result is
// registered. Reset clears counters and heap top (to the heap_base default);
// table memory is not cleared, only entries below the entry count are read.
// Depends on ffba_pkg.
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS = ffba_pkg::DEF_MAX_BLOCKS,
  parameter int ADDR_BITS  = ffba_pkg::DEF_ADDR_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ffba_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ffba_pkg::rsp_t  out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [31:0]     cfg_data_i
);
  import ffba_pkg::*;

  localparam int AW = ADDR_BITS;
  localparam int MW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int IW = $clog2(MAX_BLOCKS + 1);
  localparam int CW = (AW > 28) ? AW : 28;  // heap room compare width

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;  // zeroed alloc: size times count
  localparam logic [2:0] S_CHECK = 3'd2;  // size range check
  localparam logic [2:0] S_FSCAN = 3'd3;  // address search
  localparam logic [2:0] S_GSCAN = 3'd4;  // first-fit search
  localparam logic [2:0] S_GAPP  = 3'd5;  // append at heap top
  localparam logic [2:0] S_REL   = 3'd6;  // release old block
  localparam logic [2:0] S_OUT   = 3'd7;  // load output register

  typedef struct packed {
    logic [26:0]   size;
    logic          free;
    logic [AW-1:0] addr;
  } entry_t;

  // block table: one write port, one registered read port
  entry_t mem [MAX_BLOCKS];
  entry_t rd_q;
  logic          mem_we;
  logic [MW-1:0] mem_wa;
  logic [MW-1:0] rd_addr;
  entry_t        mem_wd;

  logic [2:0]    state_q, state_d;
  req_t          req_q, req_d;
  logic [47:0]   size_q, size_d;
  logic [AW-1:0] addr_q, addr_d;
  logic          found_q, found_d;
  logic [MW-1:0] fidx_q, fidx_d;
  logic [26:0]   fsize_q, fsize_d;
  logic          ffree_q, ffree_d;
  logic [AW-1:0] res_q, res_d;
  logic [26:0]   copy_q, copy_d;
  logic [1:0]    status_q, status_d;

  logic [IW-1:0] scan_q, scan_d;
  logic          pend_q, pend_d;
  logic [MW-1:0] pidx_q, pidx_d;

  logic [IW-1:0] ecnt_q, ecnt_d;
  logic [IW-1:0] ucnt_q, ucnt_d;
  logic [31:0]   total_q, total_d;
  logic [31:0]   used_q, used_d;
  logic [AW-1:0] top_q, top_d;
  logic [AW-1:0] limit_q, limit_d;
  logic [26:0]   maxreq_q, maxreq_d;
  logic [7:0]    hdr_q, hdr_d;

  logic          out_valid_q, out_valid_d;
  rsp_t          out_q, out_d;

  logic [CW-1:0]   need;
  logic [CW-1:0]   room;
  logic [8+IW-1:0] hprod;
  logic            is_resize;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign rd_addr     = scan_q[MW-1:0];

  assign need  = CW'(hdr_q) + CW'(size_q[26:0]);
  assign room  = CW'(limit_q - top_q);
  assign hprod = {{IW{1'b0}}, hdr_q} * {8'd0, ecnt_q};
  assign is_resize = (req_q.req_type == REQ_RESIZE);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;   req_d = req_q;     size_d = size_q;   addr_d = addr_q;
    found_d = found_q;   fidx_d = fidx_q;   fsize_d = fsize_q; ffree_d = ffree_q;
    res_d = res_q;       copy_d = copy_q;   status_d = status_q;
    scan_d = scan_q;     pend_d = pend_q;   pidx_d = pidx_q;
    ecnt_d = ecnt_q;     ucnt_d = ucnt_q;   total_d = total_q; used_d = used_q;
    top_d = top_q;       limit_d = limit_q; maxreq_d = maxreq_q; hdr_d = hdr_q;
    out_valid_d = out_valid_q;
    out_d = out_q;
    mem_we = 1'b0;
    mem_wa = pidx_q;
    mem_wd = rd_q;

    // heap_base only sets the heap top at reset, so a write to it has no effect
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HEAP_LIMIT: limit_d  = AW'(cfg_data_i);
        CFG_MAX_REQ:    maxreq_d = cfg_data_i[26:0];
        CFG_HEADER:     hdr_d    = cfg_data_i[7:0];
        default: ;
      endcase
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // scan pipeline: issue one read per cycle, check the previous one
    if (state_q == S_FSCAN || state_q == S_GSCAN) begin
      if (scan_q < ecnt_q) begin
        scan_d = scan_q + 1'b1;
        pend_d = 1'b1;
        pidx_d = scan_q[MW-1:0];
      end else begin
        pend_d = 1'b0;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_data_i;
          size_d   = {16'd0, in_data_i.request_size};
          addr_d   = AW'(in_data_i.block_address);
          found_d  = 1'b0;
          res_d    = '0;
          copy_d   = '0;
          status_d = ST_OK;
          scan_d   = '0;
          pend_d   = 1'b0;
          case (in_data_i.req_type)
            REQ_ZALLOC: state_d = S_MUL;
            REQ_FREE: begin
              state_d = (AW'(in_data_i.block_address) == '0) ? S_OUT : S_FSCAN;
            end
            default: state_d = S_CHECK;
          endcase
        end
      end
      S_MUL: begin
        size_d  = {16'd0, req_q.request_size} * {32'd0, req_q.element_count};
        state_d = S_CHECK;
      end
      S_CHECK: begin
        scan_d = '0;
        pend_d = 1'b0;
        if (size_q == '0 || size_q > {21'd0, maxreq_q}) begin
          status_d = ST_BAD_SIZE;
          state_d  = S_OUT;
        end else if (is_resize && addr_q != '0) begin
          state_d = S_FSCAN;
        end else begin
          state_d = S_GSCAN;
        end
      end
      S_FSCAN: begin
        if (pend_q && rd_q.addr == addr_q) begin
          found_d = 1'b1;
          fidx_d  = pidx_q;
          fsize_d = rd_q.size;
          ffree_d = rd_q.free;
          pend_d  = 1'b0;
          scan_d  = '0;
          if (!is_resize) begin
            state_d = S_REL;
          end else if (rd_q.size >= size_q[26:0]) begin
            res_d   = addr_q;
            state_d = S_OUT;
          end else begin
            state_d = S_GSCAN;
          end
        end else if (!pend_q && scan_q >= ecnt_q) begin
          scan_d  = '0;
          state_d = is_resize ? S_GSCAN : S_OUT;
        end
      end
      S_GSCAN: begin
        if (pend_q && rd_q.free && rd_q.size >= size_q[26:0]) begin
          mem_we      = 1'b1;
          mem_wa      = pidx_q;
          mem_wd      = rd_q;
          mem_wd.free = 1'b0;
          ucnt_d = ucnt_q + 1'b1;
          used_d = used_q + 32'(rd_q.size);
          res_d  = rd_q.addr;
          pend_d = 1'b0;
          if (is_resize && found_q) begin
            copy_d  = fsize_q;
            state_d = S_REL;
          end else begin
            state_d = S_OUT;
          end
        end else if (!pend_q && scan_q >= ecnt_q) begin
          state_d = S_GAPP;
        end
      end
      S_GAPP: begin
        if (ecnt_q >= IW'(MAX_BLOCKS)) begin
          status_d = ST_FULL;
          state_d  = S_OUT;
        end else if (top_q > limit_q || room < need) begin
          status_d = ST_EXHAUSTED;
          state_d  = S_OUT;
        end else begin
          mem_we      = 1'b1;
          mem_wa      = ecnt_q[MW-1:0];
          mem_wd.size = size_q[26:0];
          mem_wd.free = 1'b0;
          mem_wd.addr = top_q + AW'(hdr_q);
          ecnt_d  = ecnt_q + 1'b1;
          ucnt_d  = ucnt_q + 1'b1;
          top_d   = top_q + AW'(need);
          total_d = total_q + 32'(size_q[26:0]);
          used_d  = used_q + 32'(size_q[26:0]);
          res_d   = top_q + AW'(hdr_q);
          if (is_resize && found_q) begin
            copy_d  = fsize_q;
            state_d = S_REL;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_REL: begin
        if (!ffree_q) begin
          mem_we      = 1'b1;
          mem_wa      = fidx_q;
          mem_wd.size = fsize_q;
          mem_wd.free = 1'b1;
          mem_wd.addr = addr_q;
          ucnt_d = ucnt_q - 1'b1;
          used_d = used_q - 32'(fsize_q);
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d                 = 1'b1;
          out_d.result_address        = 32'(res_q);
          out_d.status                = status_q;
          out_d.copy_bytes            = copy_q;
          out_d.free_block_count      = 7'(ecnt_q - ucnt_q);
          out_d.free_byte_count       = total_q - used_q;
          out_d.allocated_block_count = 7'(ecnt_q);
          out_d.allocated_byte_count  = total_q;
          out_d.header_byte_count     = 14'(hprod);
          state_d                     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q <= '0;  size_q <= '0;  addr_q <= '0;
      found_q <= 1'b0;  fidx_q <= '0;  fsize_q <= '0;  ffree_q <= 1'b0;
      res_q <= '0;  copy_q <= '0;  status_q <= ST_OK;
      scan_q <= '0;  pend_q <= 1'b0;  pidx_q <= '0;
      ecnt_q <= '0;  ucnt_q <= '0;  total_q <= '0;  used_q <= '0;
      top_q    <= AW'(HEAP_BASE_RST);
      limit_q  <= AW'(HEAP_LIMIT_RST);
      maxreq_q <= MAX_REQUEST_RST;
      hdr_q    <= HEADER_RST;
      out_valid_q <= 1'b0;
      out_q <= '0;
    end else begin
      state_q <= state_d;
      req_q <= req_d;  size_q <= size_d;  addr_q <= addr_d;
      found_q <= found_d;  fidx_q <= fidx_d;  fsize_q <= fsize_d;  ffree_q <= ffree_d;
      res_q <= res_d;  copy_q <= copy_d;  status_q <= status_d;
      scan_q <= scan_d;  pend_q <= pend_d;  pidx_q <= pidx_d;
      ecnt_q <= ecnt_d;  ucnt_q <= ucnt_d;  total_q <= total_d;  used_q <= used_d;
      top_q <= top_d;  limit_q <= limit_d;  maxreq_q <= maxreq_d;  hdr_q <= hdr_d;
      out_valid_q <= out_valid_d;
      out_q <= out_d;
    end
  end

`ifndef SYNTH
  a_used_le_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ucnt_q <= ecnt_q) else $error("used block count above entry count");
  a_entries_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ecnt_q <= IW'(MAX_BLOCKS)) else $error("entry count above table depth");
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_GSCAN || state_q == S_GAPP || state_q == S_REL))
    else $error("table write outside update states");
  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && state_q == S_IDLE) |-> $past(state_q) != S_IDLE)
    else $error("scan read pending while idle");
`endif

endmodule
